// File: rtl/mspg_pkg.sv
`default_nettype none

package mspg_pkg;

  // axis count and field widths
  localparam int AXES      = 3;
  localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int ES_W      = 2 * AXES;
  localparam int MODE_W    = 2 * ES_W;
  localparam int STEP_BITS = 23;
  localparam int STEP_MAX  = (1 << STEP_BITS) - 1;
  localparam int STEP_IN_W = 24;
  localparam int FOLLOW_W  = 24;
  localparam int RATE_W    = 30;
  localparam int PHASE_W   = 31;
  localparam int LEAD_IN_W = 2;

  localparam int RATE_FULL_SCALE = 1073741824;
  localparam int TICK_NS         = 20000;
  localparam int NS_PER_MS       = 1000000;
  localparam int MS_W            = $clog2(NS_PER_MS + TICK_NS);

  // stream and register port widths
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 240;
  localparam int OUT_W      = 2 * AXES + 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // input word layout
  localparam int IN_STEPS_LSB  = 0;
  localparam int IN_LEAD_LSB   = 72;
  localparam int IN_INIT_LSB   = 74;
  localparam int IN_PEAK_LSB   = 104;
  localparam int IN_FINAL_LSB  = 134;
  localparam int IN_ACCEL_LSB  = 164;
  localparam int IN_DECEL_LSB  = 194;
  localparam int IN_MODES_LSB  = 217;
  localparam int IN_LEVELS_LSB = 229;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_PAUSED = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ES_NONE    = 2'd0,
    ES_HIT     = 2'd1,
    ES_NOT_HIT = 2'd2,
    ES_TOWARDS = 2'd3
  } es_mode_t;

  typedef enum logic [1:0] {
    REG_DIR_REV    = 2'd0,
    REG_ES_ACTIVE  = 2'd1,
    REG_ES_PRESENT = 2'd2,
    REG_MIN_RATE   = 2'd3
  } reg_idx_t;

  // per-move values derived from the latched block at the setup tick
  typedef struct packed {
    logic [AXES-1:0]                dirs;
    logic [ES_W-1:0]                es_en;
    logic [ES_W-1:0]                es_val;
    logic [AXES-1:0][STEP_BITS-1:0] totals;
  } setup_t;

endpackage

`default_nettype wire

// File: rtl/mspg_setup.sv
`default_nettype none

module mspg_setup (
  input  logic [mspg_pkg::AXES-1:0][mspg_pkg::STEP_IN_W-1:0] steps,
  input  logic [mspg_pkg::MODE_W-1:0]                        modes,
  input  logic [mspg_pkg::AXES-1:0]                          dir_rev,
  input  logic [mspg_pkg::AXES-1:0]                          es_active,
  input  logic [mspg_pkg::ES_W-1:0]                          es_present,
  output mspg_pkg::setup_t                                   plan
);

  always_comb begin
    logic                           neg;
    logic                           pos;
    logic [mspg_pkg::STEP_IN_W-1:0] mag;
    mspg_pkg::es_mode_t             mode;
    logic                           take;
    logic                           want;
    int                             idx;

    plan = '0;
    neg  = 1'b0;
    pos  = 1'b0;
    mag  = '0;
    mode = mspg_pkg::ES_NONE;
    take = 1'b0;
    want = 1'b0;
    idx  = 0;
    for (int a = 0; a < mspg_pkg::AXES; a++) begin
      neg = steps[a][mspg_pkg::STEP_IN_W-1];
      pos = !neg && (steps[a] != '0);
      mag = neg ? (~steps[a] + 1'b1) : steps[a];
      // most negative count saturates to the largest magnitude
      plan.totals[a] = (mag > mspg_pkg::STEP_IN_W'(mspg_pkg::STEP_MAX)) ?
                       '1 : mag[mspg_pkg::STEP_BITS-1:0];
      plan.dirs[a] = neg ^ dir_rev[a];
      for (int s = 0; s < 2; s++) begin
        idx  = 2 * a + s;
        mode = mspg_pkg::es_mode_t'(modes[2*idx +: 2]);
        // towards mode only checks the side the axis moves to
        take = (mode != mspg_pkg::ES_NONE) &&
               ((mode != mspg_pkg::ES_TOWARDS) || ((s == 1) ? pos : neg));
        want = (mode == mspg_pkg::ES_NOT_HIT) ? !es_active[a] : es_active[a];
        plan.es_en[idx]  = take && es_present[idx];
        plan.es_val[idx] = take && es_present[idx] && want;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/multi_axis_step_pulse_generator_core.sv
// an accepted word waits in the input register; its result is registered onto m_*
// throughput: one word per cycle while m_tready is high; the tick update (ramp, phase
//   accumulator, bresenham step) is combinational between the input and result registers
// reset: synchronous, active high; clears the move state, step and direction lines and the
//   registers (end-stop present resets to all ones); no clearing pass is needed
`default_nettype none

module multi_axis_step_pulse_generator_core (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mspg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mspg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mspg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  // input words
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // steps_axis0, steps_axis1, steps_axis2, lead_axis, initial_rate, peak_rate,
  // final_rate, accel_per_ms, decel_after_steps, endstop_modes, endstop_levels, zero pad
  input  logic [mspg_pkg::IN_DATA_W-1:0]      s_tdata,
  // command
  input  logic [mspg_pkg::CMD_W-1:0]          s_tuser,
  // result words
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // step_pulses, directions, busy_res, endstop_stopped
  output logic [mspg_pkg::OUT_W-1:0]          m_tdata,
  // block_done
  output logic                                m_tlast
);

  localparam int AXES    = mspg_pkg::AXES;
  localparam int AXIS_W  = mspg_pkg::AXIS_W;
  localparam int ES_W    = mspg_pkg::ES_W;
  localparam int SB      = mspg_pkg::STEP_BITS;
  localparam int FW      = mspg_pkg::FOLLOW_W;
  localparam int RW      = mspg_pkg::RATE_W;
  localparam int PW      = mspg_pkg::PHASE_W;
  localparam int MW      = mspg_pkg::MS_W;
  localparam int SIW     = mspg_pkg::STEP_IN_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOADED,
    PH_RUNNING
  } phase_t;

  // register file
  logic [AXES-1:0]          dir_rev;
  logic [AXES-1:0]          es_active;
  logic [ES_W-1:0]          es_present;
  logic [RW-1:0]            min_rate;
  mspg_pkg::reg_idx_t       cfg_idx;
  logic                     cfg_wr;

  // input register
  logic                     in_valid;
  logic [mspg_pkg::CMD_W-1:0]     in_cmd;
  logic [mspg_pkg::IN_DATA_W-1:0] in_data;
  logic                     advance;
  mspg_pkg::cmd_t           cmd;

  // latched move block
  logic [AXES-1:0][SIW-1:0] lm_steps;
  logic [AXIS_W-1:0]        lm_lead;
  logic [RW-1:0]            lm_init;
  logic [RW-1:0]            lm_peak;
  logic [RW-1:0]            lm_accel;
  logic [PW-1:0]            lm_fa;
  logic [SB-1:0]            lm_decel;
  logic [mspg_pkg::MODE_W-1:0] lm_modes;
  logic [mspg_pkg::LEAD_IN_W-1:0] lead_raw;
  logic                     load_en;

  // move state
  phase_t                   phase, phase_next;
  logic [AXES-1:0]          lines, lines_next;
  logic [AXES-1:0]          dirs, dirs_next;
  logic [AXES-1:0][SB-1:0]  counts, counts_next;
  logic [AXES-1:0][SB-1:0]  totals, totals_next;
  logic [AXES-1:0][FW-1:0]  facc, facc_next;
  logic [PW-1:0]            pacc, pacc_next;
  logic [MW-1:0]            ms_acc, ms_next;
  logic [RW-1:0]            rate, rate_next;
  logic [ES_W-1:0]          es_en, es_en_next;
  logic [ES_W-1:0]          es_val, es_val_next;
  logic                     blk_done;
  logic                     es_stop;

  // tick datapath
  mspg_pkg::setup_t         plan;
  logic [ES_W-1:0]          levels;
  logic                     es_hit;
  logic [MW-1:0]            ms_sum;
  logic                     ms_due;
  logic [SB-1:0]            lead_count;
  logic [SB-1:0]            lead_total;
  logic                     decel;
  logic [PW-1:0]            rate_up;
  logic [PW-1:0]            min_acc;
  logic                     above_floor;
  logic [RW-1:0]            rate_ramp;
  logic [RW-1:0]            init_sat;
  logic [PW-1:0]            phase_sum;
  logic                     fire;
  logic [AXES-1:0]          f_lines;
  logic [AXES-1:0][SB-1:0]  f_counts;
  logic [AXES-1:0][FW-1:0]  f_facc;
  logic [AXES-1:0]          f_more;
  logic                     moving;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign cfg_idx = mspg_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_rev    <= '0;
      es_active  <= '0;
      es_present <= '1;
      min_rate   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mspg_pkg::REG_DIR_REV:    dir_rev    <= pwdata[AXES-1:0];
        mspg_pkg::REG_ES_ACTIVE:  es_active  <= pwdata[AXES-1:0];
        mspg_pkg::REG_ES_PRESENT: es_present <= pwdata[ES_W-1:0];
        mspg_pkg::REG_MIN_RATE:   min_rate   <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mspg_pkg::REG_DIR_REV:    prdata = mspg_pkg::CFG_DATA_W'(dir_rev);
      mspg_pkg::REG_ES_ACTIVE:  prdata = mspg_pkg::CFG_DATA_W'(es_active);
      mspg_pkg::REG_ES_PRESENT: prdata = mspg_pkg::CFG_DATA_W'(es_present);
      mspg_pkg::REG_MIN_RATE:   prdata = mspg_pkg::CFG_DATA_W'(min_rate);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cmd      = mspg_pkg::cmd_t'(in_cmd);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_data <= s_tdata;
    end
  end

  // latched block, written on an accepted load
  assign lead_raw = in_data[mspg_pkg::IN_LEAD_LSB +: mspg_pkg::LEAD_IN_W];

  always_ff @(posedge clk) begin
    if (advance && load_en) begin
      for (int a = 0; a < AXES; a++) begin
        lm_steps[a] <= in_data[mspg_pkg::IN_STEPS_LSB + SIW*a +: SIW];
      end
      lm_lead  <= (lead_raw > mspg_pkg::LEAD_IN_W'(AXES - 1)) ?
                  AXIS_W'(AXES - 1) : AXIS_W'(lead_raw);
      lm_init  <= in_data[mspg_pkg::IN_INIT_LSB +: RW];
      lm_peak  <= in_data[mspg_pkg::IN_PEAK_LSB +: RW];
      lm_accel <= in_data[mspg_pkg::IN_ACCEL_LSB +: RW];
      // final rate plus one ramp step, the fixed part of the deceleration floor
      lm_fa    <= {1'b0, in_data[mspg_pkg::IN_FINAL_LSB +: RW]} +
                  {1'b0, in_data[mspg_pkg::IN_ACCEL_LSB +: RW]};
      lm_decel <= in_data[mspg_pkg::IN_DECEL_LSB +: SB];
      lm_modes <= in_data[mspg_pkg::IN_MODES_LSB +: mspg_pkg::MODE_W];
    end
  end

  mspg_setup u_setup (
    .steps      (lm_steps),
    .modes      (lm_modes),
    .dir_rev    (dir_rev),
    .es_active  (es_active),
    .es_present (es_present),
    .plan       (plan)
  );

  // ---------------------------------------------------------------- tick datapath
  assign levels     = in_data[mspg_pkg::IN_LEVELS_LSB +: ES_W];
  assign es_hit     = |(~(levels ^ es_val) & es_en);
  assign ms_sum     = ms_acc + MW'(mspg_pkg::TICK_NS);
  assign ms_due     = ms_sum >= MW'(mspg_pkg::NS_PER_MS);
  assign lead_count = counts[lm_lead];
  assign lead_total = totals[lm_lead];
  assign decel      = lead_count > lm_decel;
  assign rate_up    = {1'b0, rate} + {1'b0, lm_accel};
  assign min_acc    = {1'b0, min_rate} + {1'b0, lm_accel};
  assign above_floor = ({1'b0, rate} > min_acc) && ({1'b0, rate} > lm_fa);
  assign init_sat   = ({1'b0, lm_init} >= PW'(mspg_pkg::RATE_FULL_SCALE)) ?
                      RW'(mspg_pkg::RATE_FULL_SCALE - 1) : lm_init;

  always_comb begin
    rate_ramp = rate;
    if (ms_due) begin
      if (decel) begin
        if (above_floor) rate_ramp = rate - lm_accel;
      end else if ((rate < lm_peak) && (rate_up < PW'(mspg_pkg::RATE_FULL_SCALE))) begin
        rate_ramp = rate_up[RW-1:0];
      end
    end
  end

  assign phase_sum = pacc + {1'b0, rate_ramp};
  assign fire      = phase_sum >= PW'(mspg_pkg::RATE_FULL_SCALE);

  // lead axis steps on every fire until it reaches its total, followers through their error accumulators
  always_comb begin
    logic [FW-1:0] f_sum;
    logic [SB-1:0] inc;

    f_sum = '0;
    inc   = '0;
    for (int a = 0; a < AXES; a++) begin
      f_lines[a]  = 1'b0;
      f_more[a]   = 1'b0;
      f_counts[a] = counts[a];
      f_facc[a]   = facc[a];
      inc         = counts[a] + 1'b1;
      f_sum       = facc[a] + FW'(totals[a]);
      if (lm_lead == AXIS_W'(a)) begin
        if (counts[a] < totals[a]) begin
          f_lines[a]  = 1'b1;
          f_counts[a] = inc;
          f_more[a]   = inc < totals[a];
        end
      end else if (counts[a] != totals[a]) begin
        f_facc[a] = f_sum;
        if (f_sum >= FW'(lead_total)) begin
          f_facc[a]   = f_sum - FW'(lead_total);
          f_lines[a]  = 1'b1;
          f_counts[a] = inc;
          f_more[a]   = inc < totals[a];
        end
      end
    end
  end

  assign moving = |f_more;

  // ---------------------------------------------------------------- next state
  always_comb begin
    phase_next  = phase;
    lines_next  = lines;
    dirs_next   = dirs;
    counts_next = counts;
    totals_next = totals;
    facc_next   = facc;
    pacc_next   = pacc;
    ms_next     = ms_acc;
    rate_next   = rate;
    es_en_next  = es_en;
    es_val_next = es_val;
    load_en     = 1'b0;
    blk_done    = 1'b0;
    es_stop     = 1'b0;
    case (cmd)
      mspg_pkg::CMD_LOAD: begin
        // a load while a block is loaded or running is dropped
        if (phase == PH_IDLE) begin
          load_en    = 1'b1;
          phase_next = PH_LOADED;
        end
      end
      default: begin
        if (|lines) begin
          lines_next = '0;
        end else if (cmd == mspg_pkg::CMD_TICK && phase == PH_LOADED) begin
          totals_next = plan.totals;
          counts_next = '0;
          facc_next   = '0;
          dirs_next   = plan.dirs;
          es_en_next  = plan.es_en;
          es_val_next = plan.es_val;
          pacc_next   = '0;
          ms_next     = '0;
          rate_next   = init_sat;
          phase_next  = PH_RUNNING;
        end else if (cmd == mspg_pkg::CMD_TICK && phase == PH_RUNNING) begin
          if (es_hit) begin
            phase_next = PH_IDLE;
            blk_done   = 1'b1;
            es_stop    = 1'b1;
          end else begin
            ms_next   = ms_due ? (ms_sum - MW'(mspg_pkg::NS_PER_MS)) : ms_sum;
            rate_next = rate_ramp;
            if (fire) begin
              pacc_next   = phase_sum - PW'(mspg_pkg::RATE_FULL_SCALE);
              lines_next  = lines | f_lines;
              counts_next = f_counts;
              facc_next   = f_facc;
              if (!moving) begin
                phase_next = PH_IDLE;
                blk_done   = 1'b1;
              end
            end else begin
              pacc_next = phase_sum;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tlast  <= 1'b0;
      phase    <= PH_IDLE;
      lines    <= '0;
      dirs     <= '0;
      counts   <= '0;
      totals   <= '0;
      facc     <= '0;
      pacc     <= '0;
      ms_acc   <= '0;
      rate     <= '0;
      es_en    <= '0;
      es_val   <= '0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {es_stop, phase_next != PH_IDLE, dirs_next, lines_next};
        m_tlast  <= blk_done;
        phase    <= phase_next;
        lines    <= lines_next;
        dirs     <= dirs_next;
        counts   <= counts_next;
        totals   <= totals_next;
        facc     <= facc_next;
        pacc     <= pacc_next;
        ms_acc   <= ms_next;
        rate     <= rate_next;
        es_en    <= es_en_next;
        es_val   <= es_val_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  for (genvar gi = 0; gi < AXES; gi++) begin : g_count_chk
    a_count_le_total: assert property (@(posedge clk) disable iff (rst)
      counts[gi] <= totals[gi])
      else $error("step count passed its total");
  end

  a_phase_bounded: assert property (@(posedge clk) disable iff (rst)
    pacc < PW'(mspg_pkg::RATE_FULL_SCALE))
    else $error("phase accumulator left its range");

  a_stop_is_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[mspg_pkg::OUT_W-1] |-> m_tlast)
    else $error("end-stop stop without block done");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while both stages are stalled");

endmodule

`default_nettype wire
